// ----- hdl/dqd_pkg.sv -----
// Package: shared types, codes and transition tables of the quadrature decoder.
`timescale 1ns / 1ps
`default_nettype none
package dqd_pkg;

   // Command codes
   localparam logic [1:0] CMD_POLL       = 2'd0;
   localparam logic [1:0] CMD_READ       = 2'd1;
   localparam logic [1:0] CMD_READ_CLEAR = 2'd2;

   // Event codes
   localparam logic [2:0] EV_NONE     = 3'd0;
   localparam logic [2:0] EV_CW       = 3'd1;
   localparam logic [2:0] EV_CCW      = 3'd2;
   localparam logic [2:0] EV_INVALID  = 3'd3;
   localparam logic [2:0] EV_UNSTABLE = 3'd4;

   // Step codes held in the upper nibble of a table entry
   localparam logic [3:0] STEP_NONE = 4'h0;
   localparam logic [3:0] STEP_CW   = 4'h1;
   localparam logic [3:0] STEP_CCW  = 4'h2;
   localparam logic [3:0] STEP_BAD  = 4'h4;

   // Entry used for states outside the tables
   localparam logic [7:0] ENTRY_BAD = 8'h4F;

   localparam logic [2:0] STATE_RESET = 3'd3;
   localparam int unsigned NUM_STATES = 6;
   localparam int unsigned TAB_DEPTH  = 24;

   // Two pulses per detent
   localparam logic [7:0] TAB_TWO [TAB_DEPTH] = '{
      8'h00, 8'h04, 8'h02, 8'h4F,
      8'h10, 8'h01, 8'h4F, 8'h03,
      8'h00, 8'h4F, 8'h02, 8'h13,
      8'h4F, 8'h01, 8'h05, 8'h03,
      8'h00, 8'h04, 8'h4F, 8'h23,
      8'h20, 8'h4F, 8'h05, 8'h03
   };

   // Four pulses per detent
   localparam logic [7:0] TAB_FOUR [TAB_DEPTH] = '{
      8'h00, 8'h01, 8'h12, 8'h4F,
      8'h00, 8'h01, 8'h4F, 8'h03,
      8'h04, 8'h4F, 8'h02, 8'h03,
      8'h4F, 8'h01, 8'h02, 8'h03,
      8'h04, 8'h21, 8'h02, 8'h4F,
      8'h4F, 8'h4F, 8'h4F, 8'h4F
   };

   // Debounce outcome of one poll word
   typedef struct packed {
      logic       found;
      logic [1:0] value;
   } stable_type;

   // Result word
   typedef struct packed {
      logic signed [7:0] position;
      logic [2:0]        event_res;
   } result_type;

endpackage
`default_nettype wire

// ----- hdl/dqd_if.sv -----
// Interfaces: request and response channels of the quadrature decoder.
`timescale 1ns / 1ps
`default_nettype none
interface dqd_req_if #(
   parameter int SAMPLES_PER_POLL = 6
);
   logic                          valid;
   logic                          ready;
   logic [1:0]                    cmd;
   logic [2*SAMPLES_PER_POLL-1:0] samples;

   modport source (output valid, cmd, samples, input ready);
   modport sink   (input valid, cmd, samples, output ready);
endinterface

interface dqd_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] position;
   logic [2:0]        event_res;

   modport source (output valid, position, event_res, input ready);
   modport sink   (input valid, position, event_res, output ready);
endinterface
`default_nettype wire

// ----- hdl/dqd_debounce.sv -----
// Debounce: finds the first run of equal pin samples in a poll word.
`timescale 1ns / 1ps
`default_nettype none
module dqd_debounce #(
   parameter int SAMPLES_PER_POLL = 6,
   parameter int STABLE_COUNT     = 3
) (
   input  wire logic [2*SAMPLES_PER_POLL-1:0] samples,
   output dqd_pkg::stable_type                stable
);

   // Check every window ending at sample k; the earliest window wins
   always_comb begin
      logic ok;
      stable = '0;
      for (int k = SAMPLES_PER_POLL - 1; k >= STABLE_COUNT - 1; k--) begin
         ok = 1'b1;
         for (int j = 1; j < STABLE_COUNT; j++) begin
            if (samples[2*(k-j) +: 2] != samples[2*k +: 2]) begin
               ok = 1'b0;
            end
         end
         if (ok) begin
            stable.found = 1'b1;
            stable.value = samples[2*k +: 2];
         end
      end
   end

endmodule
`default_nettype wire

// ----- hdl/dqd_core.sv -----
// Core: decoder state, position count and the transition table step.
`timescale 1ns / 1ps
`default_nettype none
module dqd_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire logic [1:0]          cmd,
   input  wire dqd_pkg::stable_type stable,
   input  wire logic                two_pulse_mode,
   output dqd_pkg::result_type      result
);

   logic [2:0]        state_ff, state_in;
   logic signed [7:0] position_ff, position_in;
   logic [4:0]        tab_index;
   logic [7:0]        entry;

   // Look up the transition for the stored state and the stable value
   assign tab_index = {state_ff, stable.value};

   always_comb begin
      entry = dqd_pkg::ENTRY_BAD;
      if (state_ff < 3'(dqd_pkg::NUM_STATES)) begin
         entry = two_pulse_mode ? dqd_pkg::TAB_TWO[tab_index]
                                : dqd_pkg::TAB_FOUR[tab_index];
      end
   end

   // Work out next state, next count and the result word
   always_comb begin
      state_in         = state_ff;
      position_in      = position_ff;
      result.position  = position_ff;
      result.event_res = dqd_pkg::EV_NONE;
      if (cmd == dqd_pkg::CMD_POLL) begin
         if (!stable.found) begin
            result.event_res = dqd_pkg::EV_UNSTABLE;
         end else begin
            state_in = entry[2:0];
            unique case (entry[7:4])
               dqd_pkg::STEP_CW: begin
                  position_in      = position_ff + 8'sd1;
                  result.event_res = dqd_pkg::EV_CW;
               end
               dqd_pkg::STEP_CCW: begin
                  position_in      = position_ff - 8'sd1;
                  result.event_res = dqd_pkg::EV_CCW;
               end
               dqd_pkg::STEP_BAD: begin
                  state_in         = {1'b0, stable.value};
                  result.event_res = dqd_pkg::EV_INVALID;
               end
               default: begin
                  result.event_res = dqd_pkg::EV_NONE;
               end
            endcase
         end
         result.position = position_in;
      end else if (cmd == dqd_pkg::CMD_READ_CLEAR) begin
         position_in = '0;
      end
   end

   // Hold state between words; advance when a word moves to the result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= dqd_pkg::STATE_RESET;
         position_ff <= '0;
      end else if (advance) begin
         state_ff    <= state_in;
         position_ff <= position_in;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/debounced_quadrature_decoder_top.sv -----
// Top level: debounced rotary encoder decoder with registered request and response.
//
// One request word gives one response word. A poll word carries SAMPLES_PER_POLL
// two-bit pin samples, oldest in the low bits; the first run of STABLE_COUNT equal
// samples is taken as the pin value and steps the decoder through the 2- or
// 4-pulse-per-detent table chosen by csr_wdata (written when csr_we is high; the
// user must write it only while the block is idle; it does not enforce that).
// Read and read-then-clear words return the position. A word is registered in the
// request register, then the response register; the block takes a word every cycle
// while the response side keeps up, and the request register takes one more word
// while the last result waits. State updates as a word leaves the request register.
`timescale 1ns / 1ps
`default_nettype none
module debounced_quadrature_decoder_top #(
   parameter int SAMPLES_PER_POLL = 6,
   parameter int STABLE_COUNT     = 3
) (
   input  wire logic  clock,
   input  wire logic  reset,
   dqd_req_if.sink    req_if,
   dqd_rsp_if.source  rsp_if,
   input  wire logic  csr_we,
   input  wire logic  csr_wdata
);

   logic                          mode_ff;
   logic                          in_valid_ff;
   logic [1:0]                    in_cmd_ff;
   logic [2*SAMPLES_PER_POLL-1:0] in_samples_ff;
   logic                          out_valid_ff;
   dqd_pkg::result_type           out_word_ff;
   logic                          out_free;
   logic                          advance;
   dqd_pkg::stable_type           stable;
   dqd_pkg::result_type           result;

   // Flow control
   assign out_free      = !out_valid_ff || rsp_if.ready;
   assign advance       = in_valid_ff && out_free;
   assign req_if.ready  = !in_valid_ff || advance;

   assign rsp_if.valid     = out_valid_ff;
   assign rsp_if.position  = out_word_ff.position;
   assign rsp_if.event_res = out_word_ff.event_res;

   dqd_debounce #(
      .SAMPLES_PER_POLL (SAMPLES_PER_POLL),
      .STABLE_COUNT     (STABLE_COUNT)
   ) u_debounce (
      .samples (in_samples_ff),
      .stable  (stable)
   );

   dqd_core u_core (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .cmd            (in_cmd_ff),
      .stable         (stable),
      .two_pulse_mode (mode_ff),
      .result         (result)
   );

   // Mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_we) begin
         mode_ff <= csr_wdata;
      end
   end

   // Request register: take a word whenever it is empty or draining
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         in_cmd_ff     <= req_if.cmd;
         in_samples_ff <= req_if.samples;
      end
   end

   // Response register: load on advance, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= advance;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_word_ff <= result;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/dqd_checker.sv -----
// Checker: port-level properties of the quadrature decoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module dqd_port_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic signed [7:0] rsp_position,
   input wire logic [2:0]        rsp_event_res
);

   // No response word straight after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_position)
                                 && $stable(rsp_event_res))
      else $error("stalled response word changed");

   // Event codes stay in range
   a_event_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_event_res <= 3'd4)
      else $error("event code out of range");

   // With the response side idle and draining, requests are never refused
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && $past(!rsp_valid) && !$past(reset) && !$past(req_valid) |-> req_ready)
      else $error("request refused while empty");

endmodule

bind debounced_quadrature_decoder_top dqd_port_checker u_dqd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_if.valid),
   .req_ready     (req_if.ready),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_position  (rsp_if.position),
   .rsp_event_res (rsp_if.event_res)
);
`default_nettype wire
